/* rtl/ciss_pkg.sv */
// Package for the case-insensitive substring search block.
// Holds the beat structs, operation and register codes, and the case fold.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ciss_pkg;

    localparam int BYTE_W          = 8;
    localparam int PATTERN_MAX_DEF = 64;
    localparam int LEN_W           = 7;
    localparam int IDX_W           = 6;
    localparam int CNT_W           = 32;
    localparam int CFG_IDX_W       = 2;

    localparam logic [CNT_W-1:0]  CNT_SAT      = 32'hFFFF_FFFF;
    localparam logic [BYTE_W-1:0] BYTE_MASK    = 8'hFF;
    localparam logic [BYTE_W-1:0] LINE_END_RST = 8'd10;
    localparam logic [BYTE_W-1:0] CASE_OFFSET  = 8'h20;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_TEXT  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_LEN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_END  = 2'd2;

    typedef struct packed {
        logic [1:0]        operation;
        logic [BYTE_W-1:0] text_byte;
        logic              is_line_break;
        logic [IDX_W-1:0]  pattern_index;
    } t_in_item;

    typedef struct packed {
        logic             hit;
        logic [CNT_W-1:0] match_position;
        logic             search_done;
    } t_out_item;

    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  idx;
        logic [BYTE_W-1:0] data;
    } t_pat_wr;

    typedef struct packed {
        logic             we;
        logic [LEN_W-1:0] value;
    } t_len_wr;

    typedef struct packed {
        logic              shift;
        logic              clear;
        logic [BYTE_W-1:0] ch;
    } t_win_ctl;

    function automatic logic [BYTE_W-1:0] fold_case(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] r;
        r = b & BYTE_MASK;
        if (r inside {[8'h61:8'h7A]}) begin
            r = r - CASE_OFFSET;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/ciss_pattern.sv */
// Pattern store: folded pattern bytes in index order and in forward-compare order.
// A pattern length write starts a realign pass of the forward copy.
// Depends on ciss_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ciss_pattern #(
    parameter int PATTERN_MAX = ciss_pkg::PATTERN_MAX_DEF
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_rst_n,
    input  wire ciss_pkg::t_pat_wr                         i_wr,
    input  wire ciss_pkg::t_len_wr                         i_len_wr,
    input  wire logic [ciss_pkg::LEN_W-1:0]                i_len,
    output logic [PATTERN_MAX-1:0][ciss_pkg::BYTE_W-1:0]   o_pat,
    output logic [PATTERN_MAX-1:0][ciss_pkg::BYTE_W-1:0]   o_pat_fwd,
    output logic                                           o_busy
);
    import ciss_pkg::*;

    localparam int CW = $clog2(PATTERN_MAX + 1);

    logic [PATTERN_MAX-1:0][BYTE_W-1:0] r_pat;
    logic [PATTERN_MAX-1:0][BYTE_W-1:0] r_pat_fwd;
    logic [CW-1:0]                      r_sweep;
    logic [CW-1:0]                      n_sweep_start;

    always_comb begin
        if (i_len_wr.value != '0 && int'(i_len_wr.value) <= PATTERN_MAX) begin
            n_sweep_start = CW'(PATTERN_MAX - int'(i_len_wr.value));
        end else begin
            n_sweep_start = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep <= '0;
        end else if (i_len_wr.we) begin
            r_sweep <= n_sweep_start;
        end else if (r_sweep != '0) begin
            r_sweep <= r_sweep - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_len_wr.we) begin
            for (int j = 0; j < PATTERN_MAX; j++) begin
                r_pat_fwd[j] <= r_pat[PATTERN_MAX-1-j];
            end
        end else if (r_sweep != '0) begin
            for (int j = 0; j < PATTERN_MAX - 1; j++) begin
                r_pat_fwd[j] <= r_pat_fwd[j+1];
            end
        end else if (i_wr.we) begin
            for (int j = 0; j < PATTERN_MAX; j++) begin
                if (int'(i_wr.idx) < int'(i_len) &&
                    int'(i_wr.idx) + j == int'(i_len) - 1) begin
                    r_pat_fwd[j] <= i_wr.data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            for (int j = 0; j < PATTERN_MAX; j++) begin
                if (int'(i_wr.idx) == j) begin
                    r_pat[j] <= i_wr.data;
                end
            end
        end
    end

    assign o_pat     = r_pat;
    assign o_pat_fwd = r_pat_fwd;
    assign o_busy    = (r_sweep != '0);

endmodule

`default_nettype wire

/* rtl/ciss_window.sv */
// Text window shift line, fill count and the window-to-pattern compare.
// The compare looks at the window as it stands after the incoming byte.
// Depends on ciss_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ciss_window #(
    parameter int PATTERN_MAX = ciss_pkg::PATTERN_MAX_DEF
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_rst_n,
    input  wire ciss_pkg::t_win_ctl                        i_ctl,
    input  wire logic                                      i_dir,
    input  wire logic [ciss_pkg::LEN_W-1:0]                i_len,
    input  wire logic [PATTERN_MAX-1:0][ciss_pkg::BYTE_W-1:0] i_pat,
    input  wire logic [PATTERN_MAX-1:0][ciss_pkg::BYTE_W-1:0] i_pat_fwd,
    output logic                                           o_match
);
    import ciss_pkg::*;

    localparam int CW = $clog2(PATTERN_MAX + 1);

    logic [PATTERN_MAX-1:0][BYTE_W-1:0] r_win;
    logic [PATTERN_MAX-1:0][BYTE_W-1:0] n_win;
    logic [CW-1:0]                      r_fill;
    logic [CW-1:0]                      n_fill;
    logic [PATTERN_MAX-1:0]             eq;
    logic                               len_ok;

    always_comb begin
        n_win[0] = i_ctl.ch;
        for (int j = 1; j < PATTERN_MAX; j++) begin
            n_win[j] = r_win[j-1];
        end
    end

    always_comb begin
        if (int'(r_fill) < PATTERN_MAX) begin
            n_fill = r_fill + CW'(1);
        end else begin
            n_fill = r_fill;
        end
    end

    always_comb begin
        for (int j = 0; j < PATTERN_MAX; j++) begin
            eq[j] = (int'(i_len) <= j) ||
                    (n_win[j] == (i_dir ? i_pat[j] : i_pat_fwd[j]));
        end
    end

    assign len_ok  = (i_len != '0) && (int'(i_len) <= PATTERN_MAX);
    assign o_match = len_ok && (int'(n_fill) >= int'(i_len)) && (&eq);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_ctl.clear) begin
            r_fill <= '0;
        end else if (i_ctl.shift) begin
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_win <= n_win;
        end
    end

endmodule

`default_nettype wire

/* rtl/case_insensitive_substring_search.sv */
// Path: an accepted beat goes from the input register to the result register.
// Throughput: one beat per cycle when no realign pass runs and the output is not stalled.
// A pattern_length write starts a realign pass of the forward pattern copy, during which
// input beats wait in the input register.
// Reset (synchronous, active low) clears the registers to direction 0, length 0,
// line end 10, and clears the window fill, item count, found flag and valid bits.
`timescale 1ns / 1ps
`default_nettype none

module case_insensitive_substring_search #(
    parameter int PATTERN_MAX = ciss_pkg::PATTERN_MAX_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire ciss_pkg::t_in_item                 i_in_data,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output ciss_pkg::t_out_item                     o_out_data,
    input  wire logic                               i_cfg_we,
    input  wire logic [ciss_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [ciss_pkg::BYTE_W-1:0]        i_cfg_wdata
);
    import ciss_pkg::*;

    logic                               r_dir;
    logic [LEN_W-1:0]                   r_len;
    logic [BYTE_W-1:0]                  r_line_end;
    logic                               r_in_vld;
    t_in_item                           r_in;
    logic                               r_out_vld;
    t_out_item                          r_out;
    logic [CNT_W-1:0]                   r_count;
    logic                               r_found;
    logic [CNT_W-1:0]                   n_count;
    logic                               n_found;
    logic                               adv;
    logic                               busy;
    logic                               match;
    logic                               is_load;
    logic                               is_start;
    logic                               is_text;
    t_pat_wr                            pat_wr;
    t_len_wr                            len_wr;
    t_win_ctl                           win_ctl;
    logic [PATTERN_MAX-1:0][BYTE_W-1:0] pat;
    logic [PATTERN_MAX-1:0][BYTE_W-1:0] pat_fwd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir      <= 1'b0;
            r_len      <= '0;
            r_line_end <= LINE_END_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DIRECTION: r_dir      <= i_cfg_wdata[0];
                CFG_PAT_LEN:   r_len      <= i_cfg_wdata[LEN_W-1:0];
                CFG_LINE_END:  r_line_end <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign adv        = r_in_vld && !busy && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || adv;

    assign is_load  = (r_in.operation == OP_LOAD);
    assign is_start = (r_in.operation == OP_START);
    assign is_text  = (r_in.operation == OP_TEXT) && !r_found;

    always_comb begin
        pat_wr.we   = adv && is_load;
        pat_wr.idx  = r_in.pattern_index;
        pat_wr.data = fold_case(r_in.text_byte);

        len_wr.we    = i_cfg_we && (i_cfg_index == CFG_PAT_LEN);
        len_wr.value = i_cfg_wdata[LEN_W-1:0];

        win_ctl.shift = adv && is_text;
        win_ctl.clear = adv && is_start;
        win_ctl.ch    = fold_case(r_in.is_line_break ? r_line_end : r_in.text_byte);
    end

    ciss_pattern #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_pattern (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (pat_wr),
        .i_len_wr  (len_wr),
        .i_len     (r_len),
        .o_pat     (pat),
        .o_pat_fwd (pat_fwd),
        .o_busy    (busy)
    );

    ciss_window #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_window (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (win_ctl),
        .i_dir     (r_dir),
        .i_len     (r_len),
        .i_pat     (pat),
        .i_pat_fwd (pat_fwd),
        .o_match   (match)
    );

    always_comb begin
        n_count = r_count;
        n_found = r_found;
        if (is_start) begin
            n_count = '0;
            n_found = 1'b0;
        end else if (is_text) begin
            if (r_count != CNT_SAT) begin
                n_count = r_count + CNT_W'(1);
            end
            if (match) begin
                n_found = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_count   <= '0;
            r_found   <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_vld <= i_in_valid;
            end
            if (adv) begin
                r_out_vld <= 1'b1;
                r_count   <= n_count;
                r_found   <= n_found;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (adv) begin
            r_out.hit            <= is_text && match;
            r_out.match_position <= n_count;
            r_out.search_done    <= n_found;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

`ifndef ASSERT_OFF
    a_found_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_found && !n_found) |-> is_start)
        else $error("found flag cleared without a start beat");

    a_hit_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.hit) |-> r_out.search_done)
        else $error("hit reported without search_done");

    a_count_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(adv && is_start) |=> (r_count >= $past(r_count)))
        else $error("item count dropped without a start beat");

    a_hit_text: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_in.operation != OP_TEXT) |=> !r_out.hit)
        else $error("hit on a non-text beat");

    a_no_adv_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> $stable(r_count) && $stable(r_found))
        else $error("search state moved during realign pass");
`endif

endmodule

`default_nettype wire
